@@ src/quaternion_to_rotation_matrix_unit_defines.svh @@
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_DEFINES_SVH

// Same-cycle implication check, disabled while reset is asserted
`define QRM_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("qrm: same-cycle check failed");

// Next-cycle implication check, disabled while reset is asserted
`define QRM_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("qrm: next-cycle check failed");

`endif

@@ src/qrm_pkg.sv @@
`default_nettype none

package qrm_pkg;

    // Field format: signed Q1.FRAC_BITS in DATA_WIDTH bits
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    // Internal widths
    localparam int MAG_W   = DATA_WIDTH;            // magnitude, holds 2^(W-1)
    localparam int PROD_W  = 2 * DATA_WIDTH - 1;    // one exact product
    localparam int SUM_W   = 2 * DATA_WIDTH;        // sum of two products
    localparam int SQSUM_W = 2 * DATA_WIDTH + 1;    // sum of four squares
    localparam int NORM_W  = SQSUM_W - FRAC_BITS;   // squared norm, Q.FRAC_BITS
    localparam int QUO_W   = 2 * FRAC_BITS + 2;     // scale s, up to 2^(2F+1)
    localparam int MUL_W   = SUM_W + QUO_W;         // term times scale
    localparam int SHR_W   = MUL_W - 2 * FRAC_BITS; // after dropping 2F bits

    localparam int N_ELEM  = 9;

    // Front end (3) + one divider stage per quotient bit + scale (2)
    localparam int PIPE_LATENCY = 3 + QUO_W + 2;

    // Matrix element order, row major
    localparam int E_A0X = 0;
    localparam int E_A0Y = 1;
    localparam int E_A0Z = 2;
    localparam int E_A1X = 3;
    localparam int E_A1Y = 4;
    localparam int E_A1Z = 5;
    localparam int E_A2X = 6;
    localparam int E_A2Y = 7;
    localparam int E_A2Z = 8;

    // Diagonal elements take 1 - s*term, the rest signed s*term
    localparam logic [N_ELEM-1:0] DIAG_MASK = N_ELEM'((1 << E_A0X) | (1 << E_A1Y) | (1 << E_A2Z));

    localparam logic [NORM_W-1:0] NORM_ONE  = NORM_W'(1) << FRAC_BITS;
    localparam logic [QUO_W-1:0]  SCALE_TWO = QUO_W'(2) << FRAC_BITS;

    typedef logic signed [DATA_WIDTH-1:0] fix_t;

    localparam fix_t FIX_ONE = fix_t'(1) << FRAC_BITS;

    typedef struct packed {
        fix_t quat_x;
        fix_t quat_y;
        fix_t quat_z;
        fix_t quat_w;
    } quat_t;

    typedef struct packed {
        fix_t axis0_x;
        fix_t axis0_y;
        fix_t axis0_z;
        fix_t axis1_x;
        fix_t axis1_y;
        fix_t axis1_z;
        fix_t axis2_x;
        fix_t axis2_y;
        fix_t axis2_z;
    } matrix_t;

    // Unscaled element terms as sign and magnitude
    typedef struct packed {
        logic [N_ELEM-1:0]            neg;
        logic [N_ELEM-1:0][SUM_W-1:0] mag;
    } term_t;

endpackage

`default_nettype wire

@@ src/qrm_front.sv @@
`default_nettype none

// Sign split, products, squared norm and unscaled element terms
module qrm_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire qrm_pkg::quat_t quat,
    output logic                out_valid,
    output logic [qrm_pkg::NORM_W-1:0] norm,
    output qrm_pkg::term_t      terms
);
    import qrm_pkg::*;

    // cross product slots
    localparam int P_XY = 0;
    localparam int P_XZ = 1;
    localparam int P_YZ = 2;
    localparam int P_XW = 3;
    localparam int P_YW = 4;
    localparam int P_ZW = 5;

    // component slots
    localparam int C_X = 0;
    localparam int C_Y = 1;
    localparam int C_Z = 2;
    localparam int C_W = 3;

    logic [3:0][DATA_WIDTH-1:0] raw;
    logic [MAG_W-1:0]           mag_next [4];
    logic [MAG_W-1:0]           mag_reg  [4];
    logic [3:0]                 neg_next;
    logic [3:0]                 neg_reg;
    logic                       s1_valid_reg;

    logic [2*MAG_W-1:0]         sq_full    [4];
    logic [2*MAG_W-1:0]         cross_full [6];
    logic [PROD_W-1:0]          sq_reg     [4];
    logic [PROD_W-1:0]          cross_reg  [6];
    logic [3:0]                 s2_neg_reg;
    logic                       s2_valid_reg;

    logic [SQSUM_W-1:0]         sqsum;
    logic [NORM_W-1:0]          norm_next;
    logic [NORM_W-1:0]          norm_reg;
    term_t                      terms_next;
    term_t                      terms_reg;
    logic                       s3_valid_reg;

    logic                       n_xy, n_xz, n_yz, n_xw, n_yw, n_zw;

    // a*b +/- c*d on sign and magnitude; returns {neg, mag}
    function automatic logic [SUM_W:0] combine(
        input logic [PROD_W-1:0] p1,
        input logic              s1,
        input logic [PROD_W-1:0] p2,
        input logic              s2
    );
        logic [SUM_W-1:0] e1;
        logic [SUM_W-1:0] e2;
        e1 = SUM_W'(p1);
        e2 = SUM_W'(p2);
        if (s1 == s2)
        begin
            return {s1, e1 + e2};
        end
        else if (e1 >= e2)
        begin
            return {s1, e1 - e2};
        end
        else
        begin
            return {s2, e2 - e1};
        end
    endfunction

    // stage 1: sign and magnitude of each component
    assign raw = {quat.quat_w, quat.quat_z, quat.quat_y, quat.quat_x};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg_next[i] = raw[i][DATA_WIDTH-1];
            mag_next[i] = neg_next[i] ? (~raw[i] + MAG_W'(1)) : raw[i];
        end
    end

    // stage 2: squares and cross products, all exact
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq_full[i] = mag_reg[i] * mag_reg[i];
        end
        cross_full[P_XY] = mag_reg[C_X] * mag_reg[C_Y];
        cross_full[P_XZ] = mag_reg[C_X] * mag_reg[C_Z];
        cross_full[P_YZ] = mag_reg[C_Y] * mag_reg[C_Z];
        cross_full[P_XW] = mag_reg[C_X] * mag_reg[C_W];
        cross_full[P_YW] = mag_reg[C_Y] * mag_reg[C_W];
        cross_full[P_ZW] = mag_reg[C_Z] * mag_reg[C_W];
    end

    // stage 3: squared norm and the nine unscaled terms
    assign n_xy = s2_neg_reg[C_X] ^ s2_neg_reg[C_Y];
    assign n_xz = s2_neg_reg[C_X] ^ s2_neg_reg[C_Z];
    assign n_yz = s2_neg_reg[C_Y] ^ s2_neg_reg[C_Z];
    assign n_xw = s2_neg_reg[C_X] ^ s2_neg_reg[C_W];
    assign n_yw = s2_neg_reg[C_Y] ^ s2_neg_reg[C_W];
    assign n_zw = s2_neg_reg[C_Z] ^ s2_neg_reg[C_W];

    always_comb
    begin
        sqsum = SQSUM_W'(sq_reg[C_X]) + SQSUM_W'(sq_reg[C_Y])
              + SQSUM_W'(sq_reg[C_Z]) + SQSUM_W'(sq_reg[C_W]);
        norm_next = sqsum[SQSUM_W-1:FRAC_BITS];

        terms_next.neg[E_A0X] = 1'b0;
        terms_next.mag[E_A0X] = SUM_W'(sq_reg[C_Y]) + SUM_W'(sq_reg[C_Z]);
        terms_next.neg[E_A1Y] = 1'b0;
        terms_next.mag[E_A1Y] = SUM_W'(sq_reg[C_X]) + SUM_W'(sq_reg[C_Z]);
        terms_next.neg[E_A2Z] = 1'b0;
        terms_next.mag[E_A2Z] = SUM_W'(sq_reg[C_X]) + SUM_W'(sq_reg[C_Y]);

        {terms_next.neg[E_A0Y], terms_next.mag[E_A0Y]} =
            combine(cross_reg[P_XY], n_xy, cross_reg[P_ZW], ~n_zw);
        {terms_next.neg[E_A0Z], terms_next.mag[E_A0Z]} =
            combine(cross_reg[P_XZ], n_xz, cross_reg[P_YW], n_yw);
        {terms_next.neg[E_A1X], terms_next.mag[E_A1X]} =
            combine(cross_reg[P_XY], n_xy, cross_reg[P_ZW], n_zw);
        {terms_next.neg[E_A1Z], terms_next.mag[E_A1Z]} =
            combine(cross_reg[P_YZ], n_yz, cross_reg[P_XW], ~n_xw);
        {terms_next.neg[E_A2X], terms_next.mag[E_A2X]} =
            combine(cross_reg[P_XZ], n_xz, cross_reg[P_YW], ~n_yw);
        {terms_next.neg[E_A2Y], terms_next.mag[E_A2Y]} =
            combine(cross_reg[P_YZ], n_yz, cross_reg[P_XW], n_xw);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        for (int i = 0; i < 4; i++)
        begin
            sq_reg[i] <= sq_full[i][PROD_W-1:0];
        end
        for (int i = 0; i < 6; i++)
        begin
            cross_reg[i] <= cross_full[i][PROD_W-1:0];
        end
        s2_neg_reg <= neg_reg;
        norm_reg   <= norm_next;
        terms_reg  <= terms_next;
    end

    assign out_valid = s3_valid_reg;
    assign norm      = norm_reg;
    assign terms     = terms_reg;

endmodule

`default_nettype wire

@@ src/qrm_div.sv @@
`default_nettype none

`include "quaternion_to_rotation_matrix_unit_defines.svh"

// Pipelined restoring divider: s = floor(2^(2F+1) / norm), one quotient bit per stage
module qrm_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [qrm_pkg::NORM_W-1:0] norm,
    input  wire qrm_pkg::term_t         terms_in,
    output logic                        out_valid,
    output logic [qrm_pkg::QUO_W-1:0]   scale,
    output qrm_pkg::term_t              terms_out
);
    import qrm_pkg::*;

    localparam int STAGES = QUO_W;

    logic              v_reg   [STAGES];
    logic [NORM_W-1:0] nrm_reg [STAGES];
    logic [NORM_W-1:0] rem_reg [STAGES];
    logic [QUO_W-1:0]  quo_reg [STAGES];
    term_t             trm_reg [STAGES];

    logic              last_zero;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        // the dividend is a single one in its top bit
        localparam logic DBIT = (k == 0);

        logic              v_in;
        logic [NORM_W-1:0] nrm_in;
        logic [NORM_W-1:0] rem_in;
        logic [QUO_W-1:0]  quo_in;
        term_t             trm_in;
        logic [NORM_W:0]   trial;
        logic [NORM_W:0]   diff;
        logic              fits;
        logic [NORM_W-1:0] rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign nrm_in = norm;
            assign rem_in = '0;
            assign quo_in = '0;
            assign trm_in = terms_in;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[k-1];
            assign nrm_in = nrm_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign trm_in = trm_reg[k-1];
        end

        // shift in the next dividend bit, subtract if the divisor fits
        assign trial    = {rem_in, DBIT};
        assign diff     = trial - {1'b0, nrm_in};
        assign fits     = trial >= {1'b0, nrm_in};
        assign rem_next = fits ? diff[NORM_W-1:0] : trial[NORM_W-1:0];
        assign quo_next = {quo_in[QUO_W-2:0], fits};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            nrm_reg[k] <= nrm_in;
            rem_reg[k] <= rem_next;
            quo_reg[k] <= quo_next;
            trm_reg[k] <= trm_in;
        end
    end

    // a zero norm gives a zero scale, hence the identity matrix
    assign last_zero = (nrm_reg[STAGES-1] == '0);
    assign out_valid = v_reg[STAGES-1];
    assign scale     = last_zero ? '0 : quo_reg[STAGES-1];
    assign terms_out = trm_reg[STAGES-1];

    `QRM_ASSERT_IMP(a_rem_below_norm, clk, rst_n,
        v_reg[STAGES-1] && !last_zero,
        rem_reg[STAGES-1] < nrm_reg[STAGES-1])
    `QRM_ASSERT_IMP(a_unit_norm_scale, clk, rst_n,
        v_reg[STAGES-1] && (nrm_reg[STAGES-1] == NORM_ONE),
        scale == SCALE_TWO)

endmodule

`default_nettype wire

@@ src/qrm_scale.sv @@
`default_nettype none

`include "quaternion_to_rotation_matrix_unit_defines.svh"

// Scale each term by s, drop 2F fraction bits, saturate, then restore sign or subtract from one
module qrm_scale (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [qrm_pkg::QUO_W-1:0] scale,
    input  wire qrm_pkg::term_t       terms,
    output logic                      done,
    output qrm_pkg::matrix_t          matrix
);
    import qrm_pkg::*;

    localparam logic [SHR_W-1:0] SAT_OFF  = SHR_W'(1) << FRAC_BITS;
    localparam logic [SHR_W-1:0] SAT_DIAG = SHR_W'(2) << FRAC_BITS;

    logic [MUL_W-1:0]      prod_next [N_ELEM];
    logic [MUL_W-1:0]      prod_reg  [N_ELEM];
    logic [N_ELEM-1:0]     neg_reg;
    logic                  s1_valid_reg;
    logic                  s1_zero_reg;

    logic [SHR_W-1:0]      shr   [N_ELEM];
    logic [SHR_W-1:0]      lim   [N_ELEM];
    logic [DATA_WIDTH-1:0] el    [N_ELEM];
    matrix_t               matrix_next;
    matrix_t               matrix_reg;
    logic                  done_reg;

    // stage 1: one multiplier per element
    always_comb
    begin
        for (int i = 0; i < N_ELEM; i++)
        begin
            prod_next[i] = terms.mag[i] * scale;
        end
    end

    // stage 2: truncate toward zero, saturate, apply sign or subtract from one
    always_comb
    begin
        for (int i = 0; i < N_ELEM; i++)
        begin
            shr[i] = prod_reg[i][MUL_W-1:2*FRAC_BITS];
            if (DIAG_MASK[i])
            begin
                lim[i] = (shr[i] > SAT_DIAG) ? SAT_DIAG : shr[i];
                el[i]  = FIX_ONE - lim[i][DATA_WIDTH-1:0];
            end
            else
            begin
                lim[i] = (shr[i] > SAT_OFF) ? SAT_OFF : shr[i];
                el[i]  = neg_reg[i] ? (DATA_WIDTH'(0) - lim[i][DATA_WIDTH-1:0])
                                    : lim[i][DATA_WIDTH-1:0];
            end
        end
        matrix_next.axis0_x = el[E_A0X];
        matrix_next.axis0_y = el[E_A0Y];
        matrix_next.axis0_z = el[E_A0Z];
        matrix_next.axis1_x = el[E_A1X];
        matrix_next.axis1_y = el[E_A1Y];
        matrix_next.axis1_z = el[E_A1Z];
        matrix_next.axis2_x = el[E_A2X];
        matrix_next.axis2_y = el[E_A2Y];
        matrix_next.axis2_z = el[E_A2Z];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            done_reg     <= s1_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        neg_reg     <= terms.neg;
        s1_zero_reg <= (scale == '0);
        matrix_reg  <= matrix_next;
    end

    assign done   = done_reg;
    assign matrix = matrix_reg;

    `QRM_ASSERT_NXT(a_zero_gives_identity, clk, rst_n,
        s1_valid_reg && s1_zero_reg,
        done_reg && (matrix_reg.axis0_x == FIX_ONE) && (matrix_reg.axis0_y == '0)
            && (matrix_reg.axis2_z == FIX_ONE))

endmodule

`default_nettype wire

@@ src/quaternion_to_rotation_matrix_unit.sv @@
`default_nettype none

`include "quaternion_to_rotation_matrix_unit_defines.svh"

// Quaternion to 3x3 rotation matrix, signed Q1.14 in and out. One item can be
// started every clock cycle and busy is always low. Each item's matrix appears
// once it has passed the front end, divider and scale stages, marked by done
// for one cycle; the receiver cannot stall, so it must take every result as
// it comes. The depth is set by the divider that forms s = 2/|q|^2: one
// restoring step, and so one register stage, for each of its 2*FRAC_BITS+2
// quotient bits. Three stages in front form the squared norm and the product
// terms, and two after it scale and saturate. A zero quaternion gives the
// identity matrix.
module quaternion_to_rotation_matrix_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire qrm_pkg::quat_t quat,
    output logic             done,
    output qrm_pkg::matrix_t matrix
);
    import qrm_pkg::*;

    logic              front_valid;
    logic [NORM_W-1:0] front_norm;
    term_t             front_terms;
    logic              div_valid;
    logic [QUO_W-1:0]  div_scale;
    term_t             div_terms;

    // the pipeline never stalls
    assign busy = 1'b0;

    qrm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .quat      (quat),
        .out_valid (front_valid),
        .norm      (front_norm),
        .terms     (front_terms)
    );

    qrm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .norm      (front_norm),
        .terms_in  (front_terms),
        .out_valid (div_valid),
        .scale     (div_scale),
        .terms_out (div_terms)
    );

    qrm_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .scale    (div_scale),
        .terms    (div_terms),
        .done     (done),
        .matrix   (matrix)
    );

    `QRM_ASSERT_IMP(a_done_follows_start, clk, rst_n, done, $past(start, PIPE_LATENCY))

endmodule

`default_nettype wire
